// ----- sv/node_free_list_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the node free list allocator
// Property wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NODE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define NODE_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define NFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define NFL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define NFL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NFL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/nfl_pkg.sv -----
// ----------------------------------------------------------------------------
// nfl_pkg
// Types and fixed widths shared by the node free list allocator.
// ----------------------------------------------------------------------------
package nfl_pkg;

    localparam int NODE_W     = 14;
    localparam int RUN_LEN_W  = 7;
    localparam int TOUCHED_W  = 6;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_ALLOC_ONE = 2'd0,
        OP_ALLOC_RUN = 2'd1,
        OP_FREE_RUN  = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISCARD  = 2'd1,
        ST_NO_SPACE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_PUSH
    } t_state;

    typedef struct packed {
        t_op                  op;
        logic [RUN_LEN_W-1:0] len;
        logic [NODE_W-1:0]    start;
    } t_cmd;

    typedef struct packed {
        logic [NODE_W-1:0]    node;
        t_status              status;
        logic                 from_list;
        logic [TOUCHED_W-1:0] touched;
        logic                 request;
    } t_result;

endpackage

// ----- sv/nfl_front.sv -----
// ----------------------------------------------------------------------------
// nfl_front
// Input side: decodes the command and clamps the run length into a queue word.
// ----------------------------------------------------------------------------
module nfl_front #(
    parameter int MAX_RUN = 64
) (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [nfl_pkg::RUN_LEN_W-1:0] i_run_length,
    input  logic [nfl_pkg::NODE_W-1:0]    i_start_node,
    input  logic                          i_q_ready,
    output logic                          o_q_push,
    output nfl_pkg::t_cmd                 o_q_cmd
);
    import nfl_pkg::*;

    logic [RUN_LEN_W-1:0] len;

    // zero counts as one, anything past the maximum saturates
    always_comb begin
        if (i_run_length == '0) begin
            len = RUN_LEN_W'(1);
        end else if (int'(i_run_length) > MAX_RUN) begin
            len = RUN_LEN_W'(MAX_RUN);
        end else begin
            len = i_run_length;
        end
    end

    assign o_q_cmd.op    = t_op'(i_command);
    assign o_q_cmd.len   = len;
    assign o_q_cmd.start = i_start_node;
    assign o_in_ready    = i_q_ready;
    assign o_q_push      = i_in_valid & i_q_ready;

endmodule

// ----- sv/nfl_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// nfl_cmd_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module nfl_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nfl_pkg::t_cmd i_cmd,
    output logic          o_ready,
    input  logic          i_pop,
    output logic          o_valid,
    output nfl_pkg::t_cmd o_cmd
);
    import nfl_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + PTR_W'(1) : r_wr;
        n_rd    = i_pop  ? r_rd + PTR_W'(1) : r_rd;
        n_count = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/nfl_back.sv -----
// ----------------------------------------------------------------------------
// nfl_back
// Execution side: free ring RAM, bump pointer, block present bits, result reg.
// ----------------------------------------------------------------------------
`include "node_free_list_allocator_defines.svh"

module nfl_back #(
    parameter int MAX_BLOCK_COUNT = 64,
    parameter int BLOCK_NODE_BITS = 8,
    parameter int FREE_DEPTH      = 1024,
    parameter int MAX_RUN         = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  nfl_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output nfl_pkg::t_result o_result
);
    import nfl_pkg::*;

    localparam int TOTAL_NODES = MAX_BLOCK_COUNT << BLOCK_NODE_BITS;
    localparam int BLOCK_NODES = 1 << BLOCK_NODE_BITS;
    localparam int BUMP_W      = $clog2(TOTAL_NODES + 2 * MAX_RUN + 1);
    localparam int CALC_W      = (BUMP_W > NODE_W) ? BUMP_W : NODE_W;
    localparam int PTR_W       = $clog2(FREE_DEPTH);
    localparam int FILL_W      = $clog2(FREE_DEPTH + 1);
    localparam int SUM_W       = FILL_W + RUN_LEN_W;
    localparam int BLK_W       = (MAX_BLOCK_COUNT > 1) ? $clog2(MAX_BLOCK_COUNT) : 1;

    t_state                 r_state, n_state;
    logic [PTR_W-1:0]       r_rd_pos, n_rd_pos;
    logic [PTR_W-1:0]       r_wr_pos, n_wr_pos;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic [BUMP_W-1:0]      r_bump, n_bump;
    logic [MAX_BLOCK_COUNT-1:0] r_present, n_present;
    logic [NODE_W-1:0]      r_push_node, n_push_node;
    logic [RUN_LEN_W-1:0]   r_push_left, n_push_left;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    logic [NODE_W-1:0]      r_ring [FREE_DEPTH];
    logic [NODE_W-1:0]      r_rd_data;
    logic                   rd_en;
    logic                   wr_en;

    logic                   out_free;
    logic                   take;
    logic                   load;
    logic                   pop_load;
    logic [BUMP_W-1:0]      len_ext;
    logic [BUMP_W-1:0]      bump_plus_n;
    logic [BUMP_W-1:0]      first;
    logic [BUMP_W-1:0]      run_end;
    logic                   crossing;
    logic                   no_space_one;
    logic                   no_space_run;
    logic [SUM_W-1:0]       fill_sum;
    logic                   fill_fits;
    logic [BUMP_W-1:0]      alloc_node;
    logic [CALC_W-1:0]      calc_node;
    logic [CALC_W-1:0]      blk_wide;
    logic                   need_req;

    assign out_free = !r_out_valid || i_out_ready;
    assign take     = (r_state == S_IDLE) && i_q_valid && out_free;
    assign pop_load = (r_state == S_POP) && out_free;
    assign o_q_pop  = take;

    // run arithmetic
    assign len_ext      = BUMP_W'(i_q_cmd.len);
    assign bump_plus_n  = r_bump + len_ext;
    assign crossing     = (BUMP_W'(r_bump[BLOCK_NODE_BITS-1:0]) + len_ext)
                          > BUMP_W'(BLOCK_NODES);
    assign first        = crossing ? bump_plus_n : r_bump;
    assign run_end      = first + len_ext;
    assign no_space_run = run_end > BUMP_W'(TOTAL_NODES);
    assign no_space_one = (r_bump + BUMP_W'(1)) > BUMP_W'(TOTAL_NODES);
    assign fill_sum     = SUM_W'(r_fill) + SUM_W'(i_q_cmd.len);
    assign fill_fits    = fill_sum <= SUM_W'(FREE_DEPTH);

    // block lookup, shared by popped and bumped nodes
    assign alloc_node = (i_q_cmd.op == OP_ALLOC_RUN) ? first : r_bump;
    assign calc_node  = (r_state == S_POP) ? CALC_W'(r_rd_data) : CALC_W'(alloc_node);
    assign blk_wide   = calc_node >> BLOCK_NODE_BITS;
    assign need_req   = (blk_wide < CALC_W'(MAX_BLOCK_COUNT))
                        && !r_present[blk_wide[BLK_W-1:0]];

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(FREE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_q_cmd.op)
                        OP_ALLOC_ONE: if (r_fill != '0) n_state = S_POP;
                        OP_ALLOC_RUN: if (!no_space_run && crossing && fill_fits)
                                          n_state = S_PUSH;
                        OP_FREE_RUN:  if (fill_fits) n_state = S_PUSH;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_POP:   if (out_free) n_state = S_IDLE;
            S_PUSH:  if (r_push_left == RUN_LEN_W'(1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_rd_pos    = r_rd_pos;
        n_wr_pos    = r_wr_pos;
        n_fill      = r_fill;
        n_bump      = r_bump;
        n_present   = r_present;
        n_push_node = r_push_node;
        n_push_left = r_push_left;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load        = 1'b0;
        n_out       = '{node: '0, status: ST_OK, from_list: 1'b0, touched: '0,
                        request: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    case (i_q_cmd.op)
                        OP_ALLOC_ONE: begin
                            if (r_fill != '0) begin
                                rd_en    = 1'b1;
                                n_rd_pos = ring_next(r_rd_pos);
                                n_fill   = r_fill - FILL_W'(1);
                            end else if (no_space_one) begin
                                load         = 1'b1;
                                n_out.status = ST_NO_SPACE;
                            end else begin
                                load          = 1'b1;
                                n_out.node    = NODE_W'(r_bump);
                                n_out.touched = blk_wide[TOUCHED_W-1:0];
                                n_out.request = need_req;
                                n_bump        = r_bump + BUMP_W'(1);
                                if (need_req) n_present[blk_wide[BLK_W-1:0]] = 1'b1;
                            end
                        end
                        OP_ALLOC_RUN: begin
                            load = 1'b1;
                            if (no_space_run) begin
                                n_out.status = ST_NO_SPACE;
                            end else begin
                                // a crossing run hands its skipped nodes back to the ring
                                if (crossing) begin
                                    if (fill_fits) begin
                                        n_push_node = NODE_W'(r_bump);
                                        n_push_left = i_q_cmd.len;
                                        n_fill      = r_fill + FILL_W'(i_q_cmd.len);
                                    end else begin
                                        n_out.status = ST_DISCARD;
                                    end
                                end
                                n_out.node    = NODE_W'(first);
                                n_out.touched = blk_wide[TOUCHED_W-1:0];
                                n_out.request = need_req;
                                n_bump        = run_end;
                                if (need_req) n_present[blk_wide[BLK_W-1:0]] = 1'b1;
                            end
                        end
                        OP_FREE_RUN: begin
                            load       = 1'b1;
                            n_out.node = i_q_cmd.start;
                            if (fill_fits) begin
                                n_push_node = i_q_cmd.start;
                                n_push_left = i_q_cmd.len;
                                n_fill      = r_fill + FILL_W'(i_q_cmd.len);
                            end else begin
                                n_out.status = ST_DISCARD;
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (out_free) begin
                    load            = 1'b1;
                    n_out.node      = r_rd_data;
                    n_out.from_list = 1'b1;
                    n_out.touched   = blk_wide[TOUCHED_W-1:0];
                    n_out.request   = need_req;
                    if (need_req) n_present[blk_wide[BLK_W-1:0]] = 1'b1;
                end
            end
            S_PUSH: begin
                // one ring word per cycle; node indices wrap in 14 bits
                wr_en       = 1'b1;
                n_wr_pos    = ring_next(r_wr_pos);
                n_push_node = r_push_node + NODE_W'(1);
                n_push_left = r_push_left - RUN_LEN_W'(1);
            end
            default: begin
                n_out = r_out;
            end
        endcase
        n_out_valid = load || (r_out_valid && !i_out_ready);
        if (!load) n_out = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_wr_pos] <= r_push_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_ring[r_rd_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_push_node <= n_push_node;
        r_push_left <= n_push_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_pos    <= '0;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_bump      <= '0;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pos    <= n_rd_pos;
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_bump      <= n_bump;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    `NFL_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(FREE_DEPTH))
    `NFL_ASSERT_IMP(a_bump_bound, i_clk, i_rst_n, 1'b1, r_bump <= BUMP_W'(TOTAL_NODES))
    `NFL_ASSERT_IMP(a_no_take_in_push, i_clk, i_rst_n, r_state == S_PUSH, !o_q_pop)
    `NFL_ASSERT_NXT(a_pop_done, i_clk, i_rst_n, pop_load, o_out_valid && (r_state == S_IDLE))

endmodule

// ----- sv/node_free_list_allocator.sv -----
// A word is registered in the command queue; the back then loads its result register
// as it takes the word, or, for a free-list pop, after the registered ring RAM read.
// The back takes no new word while a pop waits or a free run or a crossing run writes
// its n returned nodes back (one ring write per cycle); a waiting result holds the back,
// while the two-word queue keeps taking input until full. Reset clears pointers, fill
// count, bump pointer, present bits and the queue; the ring RAM is not cleared.
// ----------------------------------------------------------------------------
// node_free_list_allocator
// Fixed-size node allocator: ring free list, bump pointer, block present bits.
// ----------------------------------------------------------------------------
module node_free_list_allocator #(
    parameter int MAX_BLOCK_COUNT = 64,
    parameter int BLOCK_NODE_BITS = 8,
    parameter int FREE_DEPTH      = 1024,
    parameter int MAX_RUN         = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [nfl_pkg::RUN_LEN_W-1:0] i_run_length,
    input  logic [nfl_pkg::NODE_W-1:0]    i_start_node,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nfl_pkg::NODE_W-1:0]    o_node_index,
    output logic [1:0]                    o_status,
    output logic                          o_from_free_list,
    output logic [nfl_pkg::TOUCHED_W-1:0] o_touched_block,
    output logic                          o_block_request
);
    import nfl_pkg::*;

    logic    q_push;
    logic    q_ready;
    t_cmd    front_cmd;
    logic    q_valid;
    logic    q_pop;
    t_cmd    q_cmd;
    t_result result;

    nfl_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_run_length (i_run_length),
        .i_start_node (i_start_node),
        .i_q_ready    (q_ready),
        .o_q_push     (q_push),
        .o_q_cmd      (front_cmd)
    );

    nfl_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    nfl_back #(
        .MAX_BLOCK_COUNT (MAX_BLOCK_COUNT),
        .BLOCK_NODE_BITS (BLOCK_NODE_BITS),
        .FREE_DEPTH      (FREE_DEPTH),
        .MAX_RUN         (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_node_index     = result.node;
    assign o_status         = result.status;
    assign o_from_free_list = result.from_list;
    assign o_touched_block  = result.touched;
    assign o_block_request  = result.request;

endmodule
